/* src/icf_pkg.sv */
`default_nettype none
package icf_pkg;

    localparam int KMAX      = 5;
    localparam int NUM_KROWS = 5;
    localparam int COEF_BITS = 8;
    localparam int MAX_WIDTH = 2048;
    localparam int LS_SLOTS  = (KMAX > 1) ? KMAX - 1 : 1;
    localparam int K_W       = $clog2(KMAX + 1);
    localparam int CNT_W     = 11;
    localparam int COL_AW    = $clog2(MAX_WIDTH);
    localparam int PIX_W     = 8;
    localparam int ROW_W     = 40;
    localparam int SCALE_W   = 24;
    localparam int SUM_W     = 22;
    localparam int PROD_W    = SUM_W + SCALE_W;
    localparam int CFG_AW    = 3;
    localparam int CFG_DW    = 40;

    localparam logic [CFG_AW-1:0] REG_KSIZE = 3'd5;
    localparam logic [CFG_AW-1:0] REG_SCALE = 3'd6;
    localparam logic [CFG_AW-1:0] REG_FRAME = 3'd7;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SHIFT,
        ST_MAC,
        ST_MUL,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic accept;
        logic shift;
        logic mac_step;
        logic mul;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic mac_last;
        logic out_busy;
    } t_status;

    function automatic logic [K_W-1:0] clamp_k(input logic [2:0] v);
        logic [K_W-1:0] r;
        if (v == 3'd0) begin
            r = K_W'(1);
        end else if (32'(v) > KMAX) begin
            r = K_W'(KMAX);
        end else begin
            r = K_W'(v);
        end
        return r;
    endfunction

endpackage
`default_nettype wire

/* src/image_convolution_filter_unit.sv */
`default_nettype none
// 2-D convolution filter over 8-bit grey pixels in raster order, kernel up to
// 5x5. A pixel at which no full window ends goes from shift straight to output;
// when a full window ends there, the weighted sum runs through a single
// multiply-accumulate unit one tap per cycle, then through a scaling multiply.
// A result waiting in the output register holds off the next request.
// The line store is one RAM of KMAX-1 packed rows; its contents are
// undefined until the first frame rows have been written.
module image_convolution_filter_unit (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_we,
    input  wire logic [icf_pkg::CFG_AW-1:0] i_cfg_idx,
    input  wire logic [icf_pkg::CFG_DW-1:0] i_cfg_data,
    input  wire logic                       s_axis_tvalid,
    output logic                            s_axis_tready,
    input  wire logic [7:0]                 s_axis_tdata,  // pixel
    output logic                            m_axis_tvalid,
    input  wire logic                       m_axis_tready,
    output logic [31:0]                     m_axis_tdata,  // filtered_value, out_row, out_col
    output logic                            m_axis_tuser,  // window_full
    output logic                            m_axis_tlast   // end_of_frame
);
    import icf_pkg::*;

    t_cmd             cmd;
    t_status          status;
    logic [PIX_W-1:0] fv;
    logic [CNT_W-1:0] orow, ocol;

    icf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    icf_datapath u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_pixel          (s_axis_tdata),
        .i_cmd            (cmd),
        .o_status         (status),
        .o_out_valid      (m_axis_tvalid),
        .i_out_ready      (m_axis_tready),
        .o_filtered_value (fv),
        .o_window_full    (m_axis_tuser),
        .o_out_row        (orow),
        .o_out_col        (ocol),
        .o_end_of_frame   (m_axis_tlast)
    );

    assign m_axis_tdata = {2'b00, ocol, orow, fv};

endmodule
`default_nettype wire

/* src/icf_ram.sv */
`default_nettype none
module icf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]              o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

/* src/icf_ctrl.sv */
`default_nettype none
module icf_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_ready,
    input  wire icf_pkg::t_status i_status,
    output icf_pkg::t_cmd        o_cmd
);
    import icf_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_SHIFT;
            end
            ST_SHIFT: begin
                n_state = ST_OUT;
            end
            ST_MAC: begin
                if (i_status.mac_last) n_state = ST_MUL;
            end
            ST_MUL: begin
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (!i_status.out_busy) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
        if (r_state == ST_SHIFT && i_status.full) n_state = ST_MAC;
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
            end
            ST_SHIFT: o_cmd.shift    = 1'b1;
            ST_MAC:   o_cmd.mac_step = 1'b1;
            ST_MUL:   o_cmd.mul      = 1'b1;
            ST_OUT:   o_cmd.load_out = !i_status.out_busy;
            default: ;
        endcase
    end

endmodule
`default_nettype wire

/* src/icf_datapath.sv */
`default_nettype none
module icf_datapath (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_we,
    input  wire logic [icf_pkg::CFG_AW-1:0]   i_cfg_idx,
    input  wire logic [icf_pkg::CFG_DW-1:0]   i_cfg_data,
    input  wire logic [icf_pkg::PIX_W-1:0]    i_pixel,
    input  wire icf_pkg::t_cmd                i_cmd,
    output icf_pkg::t_status                  o_status,
    output logic                              o_out_valid,
    input  wire logic                         i_out_ready,
    output logic [icf_pkg::PIX_W-1:0]         o_filtered_value,
    output logic                              o_window_full,
    output logic [icf_pkg::CNT_W-1:0]         o_out_row,
    output logic [icf_pkg::CNT_W-1:0]         o_out_col,
    output logic                              o_end_of_frame
);
    import icf_pkg::*;

    localparam int LS_W = LS_SLOTS * PIX_W;

    logic [ROW_W-1:0]   r_krow [NUM_KROWS];
    logic [5:0]         r_ksize;
    logic [SCALE_W-1:0] r_scale;
    logic [21:0]        r_frame;

    logic [PIX_W-1:0]   r_px;
    logic [PIX_W-1:0]   r_win [KMAX][KMAX];
    logic [CNT_W-1:0]   r_row, r_col;
    logic               r_full, r_eof;
    logic [CNT_W-1:0]   r_orow, r_ocol;
    logic [K_W-1:0]     r_k, r_l;
    logic signed [SUM_W-1:0]  r_sum;
    logic signed [PROD_W-1:0] r_prod;

    logic               r_ov;
    logic [PIX_W-1:0]   r_ofv;
    logic               r_ofull, r_oeof;
    logic [CNT_W-1:0]   r_oorow, r_oocol;

    logic [LS_W-1:0]    ls_rdata;
    logic [K_W-1:0]     fx, fy;
    logic [CNT_W-1:0]   w, h;
    logic [CNT_W:0]     row1, col1;
    logic               full, eor, eof;
    logic [PIX_W-1:0]   colv [KMAX];
    logic [K_W-1:0]     wr, wc;
    logic signed [COEF_BITS-1:0] coef;
    logic signed [COEF_BITS+PIX_W:0] mprod;
    logic signed [PROD_W:0]     t;
    logic signed [PROD_W-16:0]  q;
    logic [PIX_W-1:0]   qc;

    icf_ram #(.WIDTH(LS_W), .DEPTH(MAX_WIDTH)) u_lines (
        .i_clk   (i_clk),
        .i_we    (i_cmd.shift),
        .i_waddr (r_col[COL_AW-1:0]),
        .i_wdata ({ls_rdata[LS_W-PIX_W-1:0], r_px}),
        .i_re    (i_cmd.accept),
        .i_raddr (r_col[COL_AW-1:0]),
        .o_rdata (ls_rdata)
    );

    always_comb begin
        fx   = clamp_k(r_ksize[2:0]);
        fy   = clamp_k(r_ksize[5:3]);
        w    = (r_frame[10:0] == '0) ? CNT_W'(1) : r_frame[10:0];
        h    = (r_frame[21:11] == '0) ? CNT_W'(1) : r_frame[21:11];
        row1 = {1'b0, r_row} + (CNT_W+1)'(1);
        col1 = {1'b0, r_col} + (CNT_W+1)'(1);
        full = (row1 >= (CNT_W+1)'(fy)) && (col1 >= (CNT_W+1)'(fx));
        eor  = col1 >= {1'b0, w};
        eof  = eor && (row1 >= {1'b0, h});
        for (int r = 0; r < KMAX - 1; r++) begin
            colv[r] = ls_rdata[PIX_W*(KMAX-2-r) +: PIX_W];
        end
        colv[KMAX-1] = r_px;
        wr    = K_W'(KMAX) - fy + r_k;
        wc    = K_W'(KMAX) - fx + r_l;
        coef  = r_krow[r_k][r_l*COEF_BITS +: COEF_BITS];
        mprod = coef * $signed({1'b0, r_win[wr][wc]});
        t     = (PROD_W+1)'(r_prod) + (PROD_W+1)'(32768);
        q     = t[PROD_W:16];
        if (q < 0) begin
            qc = '0;
        end else if (q > 255) begin
            qc = '1;
        end else begin
            qc = q[PIX_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_krow[0] <= ROW_W'(65793);
            r_krow[1] <= ROW_W'(65793);
            r_krow[2] <= ROW_W'(65793);
            r_krow[3] <= '0;
            r_krow[4] <= '0;
            r_ksize   <= 6'd27;
            r_scale   <= SCALE_W'(7282);
            r_frame   <= 22'd983680;
        end else if (i_cfg_we) begin
            if (32'(i_cfg_idx) < NUM_KROWS) r_krow[i_cfg_idx] <= i_cfg_data;
            else if (i_cfg_idx == REG_KSIZE) r_ksize <= i_cfg_data[5:0];
            else if (i_cfg_idx == REG_SCALE) r_scale <= i_cfg_data[SCALE_W-1:0];
            else if (i_cfg_idx == REG_FRAME) r_frame <= i_cfg_data[21:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
            r_ov  <= 1'b0;
            for (int r = 0; r < KMAX; r++) begin
                for (int c = 0; c < KMAX; c++) begin
                    r_win[r][c] <= '0;
                end
            end
        end else begin
            if (i_cmd.accept) r_px <= i_pixel;
            if (i_cmd.shift) begin
                for (int r = 0; r < KMAX; r++) begin
                    for (int c = 0; c < KMAX - 1; c++) begin
                        r_win[r][c] <= r_win[r][c+1];
                    end
                    r_win[r][KMAX-1] <= colv[r];
                end
                r_full <= full;
                r_eof  <= eof;
                r_orow <= row1[CNT_W-1:0] - CNT_W'(fy) + CNT_W'(fy >> 1);
                r_ocol <= col1[CNT_W-1:0] - CNT_W'(fx) + CNT_W'(fx >> 1);
                r_sum  <= '0;
                r_k    <= '0;
                r_l    <= '0;
                if (eor) begin
                    r_col <= '0;
                    r_row <= eof ? '0 : row1[CNT_W-1:0];
                end else begin
                    r_col <= col1[CNT_W-1:0];
                end
            end
            if (i_cmd.mac_step) begin
                r_sum <= r_sum + SUM_W'(mprod);
                if (r_l == fx - K_W'(1)) begin
                    r_l <= '0;
                    r_k <= r_k + K_W'(1);
                end else begin
                    r_l <= r_l + K_W'(1);
                end
            end
            if (i_cmd.mul) r_prod <= r_sum * $signed(r_scale);
            if (i_cmd.load_out) begin
                r_ov    <= 1'b1;
                r_ofull <= r_full;
                r_ofv   <= r_full ? qc : '0;
                r_oorow <= r_full ? r_orow : '0;
                r_oocol <= r_full ? r_ocol : '0;
                r_oeof  <= r_eof;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_comb begin
        o_status.full     = full;
        o_status.mac_last = (r_k == fy - K_W'(1)) && (r_l == fx - K_W'(1));
        o_status.out_busy = r_ov && !i_out_ready;
        o_out_valid       = r_ov;
        o_filtered_value  = r_ofv;
        o_window_full     = r_ofull;
        o_out_row         = r_oorow;
        o_out_col         = r_oocol;
        o_end_of_frame    = r_oeof;
    end

endmodule
`default_nettype wire
